### rtl/core/sia_pkg.sv
// Shared types, operation codes and a helper function for the SQL integer ALU.
`timescale 1ns / 1ps
package sia_pkg;

    // Operation codes
    localparam logic [4:0] FN_ADD    = 5'd0;
    localparam logic [4:0] FN_SUB    = 5'd1;
    localparam logic [4:0] FN_MUL    = 5'd2;
    localparam logic [4:0] FN_DIV    = 5'd3;
    localparam logic [4:0] FN_MOD    = 5'd4;
    localparam logic [4:0] FN_NEG    = 5'd5;
    localparam logic [4:0] FN_ABS    = 5'd6;
    localparam logic [4:0] FN_INC    = 5'd7;
    localparam logic [4:0] FN_CMP    = 5'd8;
    localparam logic [4:0] FN_EQ     = 5'd9;
    localparam logic [4:0] FN_NE     = 5'd10;
    localparam logic [4:0] FN_LT     = 5'd11;
    localparam logic [4:0] FN_LE     = 5'd12;
    localparam logic [4:0] FN_GT     = 5'd13;
    localparam logic [4:0] FN_GE     = 5'd14;
    localparam logic [4:0] FN_WIDEN  = 5'd15;
    localparam logic [4:0] FN_NARROW = 5'd16;

    // Width codes
    localparam logic [1:0] W_16  = 2'd0;
    localparam logic [1:0] W_32  = 2'd1;
    localparam logic [1:0] W_64  = 2'd2;
    localparam logic [1:0] W_BAD = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_UNSUPP = 2'd3;

    // Back-end work kinds
    localparam logic [1:0] K_SIMPLE = 2'd0;
    localparam logic [1:0] K_MUL    = 2'd1;
    localparam logic [1:0] K_DIV    = 2'd2;
    localparam logic [1:0] K_MOD    = 2'd3;

    localparam int DATA_W     = 64;
    localparam int DIV_STEPS  = DATA_W;
    localparam int FIFO_DEPTH = 2;

    // Range accepted by the 32-to-16 narrow
    localparam logic signed [63:0] NARROW_LO = -64'sd32768;
    localparam logic signed [63:0] NARROW_HI = 64'sd32767;

    // Classified item handed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  wsel;
        logic [1:0]  status;
        logic [63:0] value;
        logic [63:0] a;
        logic [63:0] b;
    } front_item_t;

    // Sign-extend the low 16 or 32 bits, or pass 64 bits through
    function automatic logic [63:0] sext_w(input logic [63:0] x, input logic [1:0] wsel);
        logic [63:0] r;
        unique case (wsel)
            W_16:    r = {{48{x[15]}}, x[15:0]};
            W_32:    r = {{32{x[31]}}, x[31:0]};
            default: r = x;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/sia_front.sv
// Front end: registers a transaction, sign-extends operands, checks status, does simple ops.
`timescale 1ns / 1ps
module sia_front
    import sia_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  func,
    input  logic [1:0]  width_sel,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        item_valid,
    input  logic        item_ready,
    output front_item_t item
);

    logic        valid_reg;
    front_item_t item_reg;
    front_item_t item_next;

    logic [63:0] a, b, r, nar;
    logic        lt, gt, eq;

    // Classification and the simple operations
    always_comb begin
        a   = sext_w(operand_a, width_sel);
        b   = sext_w(operand_b, width_sel);
        lt  = $signed(a) < $signed(b);
        gt  = $signed(b) < $signed(a);
        eq  = (a == b);
        nar = {{32{operand_a[31]}}, operand_a[31:0]};
        case (func)
            FN_ADD:  r = a + b;
            FN_SUB:  r = a - b;
            FN_NEG:  r = 64'd0 - a;
            FN_ABS:  r = a[63] ? 64'd0 - a : a;
            FN_INC:  r = a + 64'd1;
            FN_CMP:  r = lt ? {64{1'b1}} : {63'd0, gt};
            FN_EQ:   r = {63'd0, eq};
            FN_NE:   r = {63'd0, !eq};
            FN_LT:   r = {63'd0, lt};
            FN_LE:   r = {63'd0, !gt};
            FN_GT:   r = {63'd0, gt};
            FN_GE:   r = {63'd0, !lt};
            default: r = 64'd0;
        endcase

        item_next.wsel   = width_sel;
        item_next.a      = a;
        item_next.b      = b;
        item_next.kind   = K_SIMPLE;
        item_next.status = ST_OK;
        item_next.value  = sext_w(r, width_sel);
        case (func)
            FN_MUL: item_next.kind = K_MUL;
            FN_DIV: item_next.kind = K_DIV;
            FN_MOD: item_next.kind = K_MOD;
            default: item_next.kind = K_SIMPLE;
        endcase

        if (func == FN_WIDEN) begin
            item_next.value = {{48{operand_a[15]}}, operand_a[15:0]};
        end else if (func == FN_NARROW) begin
            item_next.value = nar;
            if ($signed(nar) < NARROW_LO || $signed(nar) > NARROW_HI) begin
                item_next.status = ST_RANGE;
            end
        end else if (func > FN_NARROW || width_sel == W_BAD) begin
            item_next.status = ST_UNSUPP;
        end else if (width_sel == W_16 && func >= FN_MOD && func <= FN_INC) begin
            item_next.status = ST_UNSUPP;
        end else if ((func == FN_DIV || func == FN_MOD) && b == 64'd0) begin
            item_next.status = ST_DIV0;
        end
        if (item_next.status != ST_OK) begin
            item_next.value = 64'd0;
            item_next.kind  = K_SIMPLE;
        end
    end

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/core/sia_fifo.sv
// Two-entry queue between the front end and the execution pipeline.
`timescale 1ns / 1ps
module sia_fifo
    import sia_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  front_item_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output front_item_t pop_item
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    front_item_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]         count_reg;
    logic                   push, pop;

    assign push_ready = (count_reg != FIFO_DEPTH[PTR_W:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/sia_back.sv
// Execution pipeline: split multiplier, one-bit-per-stage divider and output register.
`timescale 1ns / 1ps
module sia_back
    import sia_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    output logic        item_ready,
    input  front_item_t item,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [63:0] res_value,
    output logic [1:0]  res_status
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  wsel;
        logic [1:0]  status;
        logic [63:0] value;
        logic        neg_q;
        logic        neg_r;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dvs;
    } stage_t;

    stage_t             stage_reg [DIV_STEPS+1];
    stage_t             stage_next [DIV_STEPS+1];
    logic [DIV_STEPS:0] valid_reg;
    logic [63:0]        pll_reg;
    logic [31:0]        plh_reg, phl_reg;
    logic [31:0]        pmid;
    logic [63:0]        prod;
    logic               en;
    logic               out_valid_reg;
    logic [63:0]        out_value_reg, out_value_next;
    logic [1:0]         out_status_reg;
    stage_t             last;

    // Whole pipeline moves unless the output register is held
    assign en         = !out_valid_reg || res_ready;
    assign item_ready = en;

    assign pmid = plh_reg + phl_reg;
    assign prod = pll_reg + {pmid, 32'd0};

    // Entry stage takes magnitudes; then a restoring divider, one quotient bit per stage
    always_comb begin
        logic [64:0] trial;
        logic [64:0] diff;
        stage_next[0].kind   = item.kind;
        stage_next[0].wsel   = item.wsel;
        stage_next[0].status = item.status;
        stage_next[0].value  = item.value;
        stage_next[0].neg_q  = item.a[63] ^ item.b[63];
        stage_next[0].neg_r  = item.a[63];
        stage_next[0].rem    = 64'd0;
        stage_next[0].quo    = item.a[63] ? 64'd0 - item.a : item.a;
        stage_next[0].dvs    = item.b[63] ? 64'd0 - item.b : item.b;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            trial             = {stage_reg[k-1].rem, stage_reg[k-1].quo[63]};
            diff              = trial - {1'b0, stage_reg[k-1].dvs};
            stage_next[k]     = stage_reg[k-1];
            stage_next[k].rem = diff[64] ? trial[63:0] : diff[63:0];
            stage_next[k].quo = {stage_reg[k-1].quo[62:0], !diff[64]};
        end
        // Product lands in the first divider stage
        if (stage_reg[0].kind == K_MUL) begin
            stage_next[1].value = prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    // Partial products for the multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            pll_reg <= 64'(item.a[31:0]) * 64'(item.b[31:0]);
            plh_reg <= 32'(item.a[31:0] * item.b[63:32]);
            phl_reg <= 32'(item.a[63:32] * item.b[31:0]);
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DIV_STEPS-1:0], item_valid};
        end
    end

    // Result select and sign fix
    always_comb begin
        last = stage_reg[DIV_STEPS];
        case (last.kind)
            K_MUL:   out_value_next = sext_w(last.value, last.wsel);
            K_DIV:   out_value_next = sext_w(last.neg_q ? 64'd0 - last.quo : last.quo,
                                             last.wsel);
            K_MOD:   out_value_next = sext_w(last.neg_r ? 64'd0 - last.rem : last.rem,
                                             last.wsel);
            default: out_value_next = last.value;
        endcase
        if (last.status != ST_OK) begin
            out_value_next = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_value_reg  <= out_value_next;
            out_status_reg <= last.status;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_value  = out_value_reg;
    assign res_status = out_status_reg;

endmodule

### rtl/core/sql_integer_alu_unit.sv
// Top level of the SQL integer ALU: front end, queue and execution pipeline.
// Usage:
//   s_ channel carries one operation per transaction: func, width_sel and two
//   64-bit operands. m_ channel returns one transaction per input: a 64-bit
//   sign-extended result and a 2-bit status, in input order.
// Throughput: one transaction per cycle sustained while m_tready stays high; a
//   new item may follow in the very next cycle.
// Path: every operation passes in order through the front register, the queue,
//   the entry stage (split 32-bit partial products), the divider, which
//   resolves one quotient bit per stage over 64 stages, and the output register.
// Reset: aresetn low clears all valid bits; nothing is in flight afterward.
// Stall: when m_tready is low with a result waiting, the execution pipeline
//   holds; the front register and the two-entry queue keep taking up to three
//   more transactions before s_tready drops.
`timescale 1ns / 1ps
module sql_integer_alu_unit
    import sia_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // func[4:0], width_sel[6:5], operand_a[70:7],
                                    // operand_b[134:71], zero pad[135]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // result_value[63:0], status[65:64], zero pad[71:66]
);

    logic        f_valid, f_ready, q_valid, q_ready;
    front_item_t f_item, q_item;
    logic [63:0] res_value;
    logic [1:0]  res_status;

    sia_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tdata[4:0]),
        .width_sel  (s_tdata[6:5]),
        .operand_a  (s_tdata[70:7]),
        .operand_b  (s_tdata[134:71]),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    sia_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    sia_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_value  (res_value),
        .res_status (res_status)
    );

    assign m_tdata = {6'd0, res_status, res_value};

endmodule

### rtl/core/sia_checker.sv
// Port-level checks for the SQL integer ALU, bound to the top level.
`timescale 1ns / 1ps
module sia_checker
    import sia_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata
);

    // Any error status comes with a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65:64] != ST_OK |-> m_tdata[63:0] == 64'd0)
        else $error("nonzero result with error status");

    // Pad bits stay clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:66] == 6'd0)
        else $error("output pad bits set");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Input side is open right after reset
    a_ready_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // A stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

endmodule

bind sql_integer_alu_unit sia_checker u_sia_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
